@@ rtl/tcs_pkg.sv @@
// shared types, constants and helper functions of the textured column sampler
`default_nettype none

package tcs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    // register widths and reset values
    localparam int CFG_TEX_W = 7;
    localparam int CFG_SH_W  = 13;
    localparam logic [CFG_TEX_W-1:0] TEX_WIDTH_RST     = 7'd64;
    localparam logic [CFG_TEX_W-1:0] TEX_HEIGHT_RST    = 7'd64;
    localparam logic [CFG_SH_W-1:0]  SCREEN_HEIGHT_RST = 13'd480;

    // texture size limits
    localparam int TEX_MAX_WIDTH  = 64;
    localparam int TEX_MAX_HEIGHT = 64;

    // fixed point
    localparam int FRAC_BITS_DEF = 16;
    localparam int WALL_FRAC     = 16;
    localparam int LH_W          = 16;
    localparam int OFF_W         = 17;

    // rows and texture memory
    localparam int ROW_W     = 13;
    localparam logic [ROW_W-1:0] ROW_LIMIT = 13'd4096;
    localparam int MEM_AW    = 12;
    localparam int MEM_DEPTH = 4096;
    localparam int TEXEL_W   = 32;

    // item actions
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_COLUMN = 2'd1;
    localparam logic [1:0] ACT_ROW    = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [MEM_AW-1:0]  tex_addr;
        logic [TEXEL_W-1:0] texel;
        logic [11:0]        screen_x;
        logic [11:0]        draw_start;
        logic [12:0]        draw_end;
        logic [LH_W-1:0]    line_height;
        logic [15:0]        wall_x;
    } t_in_item;

    typedef struct packed {
        logic [11:0]        pixel_x;
        logic [11:0]        pixel_y;
        logic [TEXEL_W-1:0] color;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic               we;
        logic [MEM_AW-1:0]  wr_addr;
        logic [TEXEL_W-1:0] wr_data;
        logic               rd_en;
        logic [MEM_AW-1:0]  rd_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ENG_HOLD,
        ENG_MUL_LOAD,
        ENG_MUL_STEP,
        ENG_DIV_LOAD,
        ENG_DIV_STEP,
        ENG_ACC_ADD
    } t_eng_op;

    function automatic logic [CFG_TEX_W-1:0] clamp_size(input logic [CFG_TEX_W-1:0] v,
                                                        input int max_v);
        logic [CFG_TEX_W-1:0] res;
        if (v == '0) begin
            res = CFG_TEX_W'(1);
        end else if (int'(v) > max_v) begin
            res = CFG_TEX_W'(max_v);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [TEXEL_W-1:0] byte_reverse(input logic [TEXEL_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/tcs_texmem.sv @@
// texture memory with one write port and one registered read port
`default_nettype none

module tcs_texmem (
    input  logic                         i_clk,
    input  tcs_pkg::t_mem_req            i_req,
    output logic [tcs_pkg::TEXEL_W-1:0]  o_rd_data
);

    logic [tcs_pkg::TEXEL_W-1:0] r_mem [tcs_pkg::MEM_DEPTH];
    logic [tcs_pkg::TEXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/tcs_engine.sv @@
// shared add/subtract unit doing shift-add multiply, restoring divide and accumulate
`default_nettype none

module tcs_engine #(
    parameter  int FRAC_BITS = tcs_pkg::FRAC_BITS_DEF,
    localparam int STEP_W    = tcs_pkg::CFG_TEX_W + FRAC_BITS,
    localparam int POS_W     = tcs_pkg::OFF_W + STEP_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcs_pkg::t_eng_op           i_op,
    input  logic [POS_W-1:0]           i_a,
    input  logic [STEP_W-1:0]          i_b,
    input  logic [tcs_pkg::LH_W-1:0]   i_divisor,
    output logic [POS_W-1:0]           o_acc,
    output logic [STEP_W-1:0]          o_shift
);

    localparam int LH_W = tcs_pkg::LH_W;

    logic [POS_W-1:0]  r_acc;
    logic [POS_W-1:0]  r_mcand;
    logic [STEP_W-1:0] r_shift;
    logic [LH_W-1:0]   r_rem;
    logic [LH_W-1:0]   r_div;

    logic [POS_W-1:0]  w_opa;
    logic [POS_W-1:0]  w_opb;
    logic              w_sub;
    logic [POS_W-1:0]  w_sum;
    logic              w_neg;

    always_comb begin
        w_sub = 1'b0;
        w_opa = r_acc;
        w_opb = r_mcand;
        case (i_op)
            tcs_pkg::ENG_DIV_STEP: begin
                w_sub = 1'b1;
                w_opa = POS_W'({r_rem, r_shift[STEP_W-1]});
                w_opb = POS_W'(r_div);
            end
            tcs_pkg::ENG_ACC_ADD: begin
                w_opb = i_a;
            end
            default: begin
            end
        endcase
        w_sum = w_opa + (w_opb ^ {POS_W{w_sub}}) + POS_W'(w_sub);
        w_neg = w_sum[POS_W-1];
    end

    // accumulator holds the texture position between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            case (i_op)
                tcs_pkg::ENG_MUL_LOAD: r_acc <= '0;
                tcs_pkg::ENG_MUL_STEP: begin
                    if (r_shift[0]) begin
                        r_acc <= w_sum;
                    end
                end
                tcs_pkg::ENG_ACC_ADD:  r_acc <= w_sum;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            tcs_pkg::ENG_HOLD: begin
            end
            tcs_pkg::ENG_MUL_LOAD: begin
                r_mcand <= i_a;
                r_shift <= i_b;
            end
            tcs_pkg::ENG_MUL_STEP: begin
                r_mcand <= {r_mcand[POS_W-2:0], 1'b0};
                r_shift <= {1'b0, r_shift[STEP_W-1:1]};
            end
            tcs_pkg::ENG_DIV_LOAD: begin
                r_rem   <= '0;
                r_shift <= i_b;
                r_div   <= i_divisor;
            end
            tcs_pkg::ENG_DIV_STEP: begin
                if (!w_neg) begin
                    r_rem   <= w_sum[LH_W-1:0];
                    r_shift <= {r_shift[STEP_W-2:0], 1'b1};
                end else begin
                    r_rem   <= {r_rem[LH_W-2:0], r_shift[STEP_W-1]};
                    r_shift <= {r_shift[STEP_W-2:0], 1'b0};
                end
            end
            tcs_pkg::ENG_ACC_ADD: begin
            end
        endcase
    end

    assign o_acc   = r_acc;
    assign o_shift = r_shift;

endmodule

`default_nettype wire

@@ rtl/textured_column_sampler_core.sv @@
// top level: sequencer, row addressing and output register of the textured column sampler
//
// channel   direction  handshake              payload
// item      in         start & !busy          i_item (t_in_item)
// result    out        o_strobe, one cycle    o_result (t_out_item)
// config    in         i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// write item: busy stays low
// row item in the span: busy through the address, memory read and output states, o_strobe after
// row item past the span end or unused action: busy stays low
// column item: busy for the bit-serial multiply and divide iterations of the shared
// add/subtract unit
// reset is synchronous and active low; the receiver cannot stall results
`default_nettype none

module textured_column_sampler_core #(
    parameter int FRAC_BITS = tcs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tcs_pkg::t_in_item                 i_item,
    output logic                              o_strobe,
    output tcs_pkg::t_out_item                o_result,
    input  logic                              i_cfg_we,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int TW      = tcs_pkg::CFG_TEX_W;
    localparam int STEP_W  = TW + FRAC_BITS;
    localparam int POS_W   = tcs_pkg::OFF_W + STEP_W;
    localparam int WHOLE_W = POS_W - FRAC_BITS;
    localparam int OFF_W   = tcs_pkg::OFF_W;
    localparam int LH_W    = tcs_pkg::LH_W;
    localparam int ROW_W   = tcs_pkg::ROW_W;
    localparam int AW      = tcs_pkg::MEM_AW;
    localparam int CNT_W   = $clog2(STEP_W + 1);
    localparam int PROD_W  = 2 * TW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TX,
        S_DIV,
        S_MUL,
        S_ROW_ADDR,
        S_ROW_READ,
        S_ROW_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    logic [TW-1:0]           r_tex_width;
    logic [TW-1:0]           r_tex_height;
    logic [tcs_pkg::CFG_SH_W-1:0] r_screen_height;

    logic [LH_W-1:0]         r_lh;
    logic [OFF_W-1:0]        r_offset;
    logic [TW-1:0]           r_tex_col;
    logic [STEP_W-1:0]       r_step;
    logic [ROW_W-1:0]        r_cur_row;
    logic [ROW_W-1:0]        r_end_row;
    logic [11:0]             r_col_x;
    logic [AW-1:0]           r_rd_addr;
    logic [11:0]             r_pend_y;
    logic                    r_pend_last;
    logic                    r_strobe;
    tcs_pkg::t_out_item      r_result;

    logic                    w_accept;
    logic [TW-1:0]           w_tw;
    logic [TW-1:0]           w_th;
    logic [LH_W-1:0]         w_lh1;
    logic [OFF_W-1:0]        w_offset;
    logic [TW-1:0]           w_tx;
    logic [TW-1:0]           w_tx_clamped;
    logic [WHOLE_W-1:0]      w_whole;
    logic [TW-1:0]           w_ty;
    logic [PROD_W-1:0]       w_prod;
    logic [AW-1:0]           w_addr;

    tcs_pkg::t_eng_op        w_op;
    logic [POS_W-1:0]        w_eng_a;
    logic [STEP_W-1:0]       w_eng_b;
    logic [POS_W-1:0]        w_eng_acc;
    logic [STEP_W-1:0]       w_eng_shift;

    tcs_pkg::t_mem_req       w_mem_req;
    logic [tcs_pkg::TEXEL_W-1:0] w_rd_data;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_tw  = tcs_pkg::clamp_size(r_tex_width, tcs_pkg::TEX_MAX_WIDTH);
    assign w_th  = tcs_pkg::clamp_size(r_tex_height, tcs_pkg::TEX_MAX_HEIGHT);
    assign w_lh1 = (i_item.line_height == '0) ? LH_W'(1) : i_item.line_height;
    assign w_offset = OFF_W'(i_item.draw_start)
                    - OFF_W'(r_screen_height[tcs_pkg::CFG_SH_W-1:1])
                    + OFF_W'(w_lh1[LH_W-1:1]);

    // texture column from the wall fraction product
    assign w_tx         = w_eng_acc[tcs_pkg::WALL_FRAC +: TW];
    assign w_tx_clamped = (w_tx >= w_tw) ? TW'(w_tw - TW'(1)) : w_tx;

    // texture row from the current position, then texel address
    assign w_whole = w_eng_acc[POS_W-1:FRAC_BITS];
    always_comb begin
        if (w_eng_acc[POS_W-1]) begin
            w_ty = '0;
        end else if (w_whole >= WHOLE_W'(w_th)) begin
            w_ty = TW'(w_th - TW'(1));
        end else begin
            w_ty = w_whole[TW-1:0];
        end
    end
    assign w_prod = PROD_W'(w_ty) * PROD_W'(w_tw);
    assign w_addr = AW'(w_prod + PROD_W'(r_tex_col));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_op    = tcs_pkg::ENG_HOLD;
        w_eng_a = '0;
        w_eng_b = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.action)
                        tcs_pkg::ACT_COLUMN: begin
                            n_state = S_TX;
                            n_cnt   = CNT_W'(TW);
                            w_op    = tcs_pkg::ENG_MUL_LOAD;
                            w_eng_a = POS_W'(i_item.wall_x);
                            w_eng_b = STEP_W'(w_tw);
                        end
                        tcs_pkg::ACT_ROW: begin
                            if (r_cur_row < r_end_row) begin
                                n_state = S_ROW_ADDR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TX: begin
                if (r_cnt != '0) begin
                    w_op  = tcs_pkg::ENG_MUL_STEP;
                    n_cnt = CNT_W'(r_cnt - CNT_W'(1));
                end else begin
                    w_op    = tcs_pkg::ENG_DIV_LOAD;
                    w_eng_b = {w_th, {FRAC_BITS{1'b0}}};
                    n_cnt   = CNT_W'(STEP_W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt != '0) begin
                    w_op  = tcs_pkg::ENG_DIV_STEP;
                    n_cnt = CNT_W'(r_cnt - CNT_W'(1));
                end else begin
                    w_op    = tcs_pkg::ENG_MUL_LOAD;
                    w_eng_a = {{(POS_W-OFF_W){r_offset[OFF_W-1]}}, r_offset};
                    w_eng_b = w_eng_shift;
                    n_cnt   = CNT_W'(STEP_W);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt != '0) begin
                    w_op  = tcs_pkg::ENG_MUL_STEP;
                    n_cnt = CNT_W'(r_cnt - CNT_W'(1));
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROW_ADDR: begin
                w_op    = tcs_pkg::ENG_ACC_ADD;
                w_eng_a = POS_W'(r_step);
                n_state = S_ROW_READ;
            end
            S_ROW_READ: n_state = S_ROW_OUT;
            S_ROW_OUT:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_tex_col <= '0;
            r_step    <= '0;
            r_cur_row <= '0;
            r_end_row <= '0;
            r_col_x   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= (r_state == S_ROW_OUT);
            if (w_accept && i_item.action == tcs_pkg::ACT_COLUMN) begin
                r_lh      <= w_lh1;
                r_offset  <= w_offset;
                r_col_x   <= i_item.screen_x;
                r_cur_row <= ROW_W'(i_item.draw_start);
                r_end_row <= (i_item.draw_end > tcs_pkg::ROW_LIMIT) ? tcs_pkg::ROW_LIMIT
                                                                     : i_item.draw_end;
            end
            if (r_state == S_TX && r_cnt == '0) begin
                r_tex_col <= w_tx_clamped;
            end
            if (r_state == S_DIV && r_cnt == '0) begin
                r_step <= w_eng_shift;
            end
            if (r_state == S_ROW_ADDR) begin
                r_rd_addr   <= w_addr;
                r_pend_y    <= r_cur_row[11:0];
                r_pend_last <= (ROW_W'(r_cur_row + ROW_W'(1)) == r_end_row);
                r_cur_row   <= ROW_W'(r_cur_row + ROW_W'(1));
            end
            if (r_state == S_ROW_OUT) begin
                r_result <= '{pixel_x: r_col_x,
                              pixel_y: r_pend_y,
                              color:   tcs_pkg::byte_reverse(w_rd_data),
                              last:    r_pend_last};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width     <= tcs_pkg::TEX_WIDTH_RST;
            r_tex_height    <= tcs_pkg::TEX_HEIGHT_RST;
            r_screen_height <= tcs_pkg::SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcs_pkg::CFG_TEX_WIDTH:     r_tex_width     <= i_cfg_wdata[TW-1:0];
                tcs_pkg::CFG_TEX_HEIGHT:    r_tex_height    <= i_cfg_wdata[TW-1:0];
                tcs_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_mem_req = '{we:      w_accept && (i_item.action == tcs_pkg::ACT_WRITE),
                         wr_addr: i_item.tex_addr,
                         wr_data: i_item.texel,
                         rd_en:   (r_state == S_ROW_READ),
                         rd_addr: r_rd_addr};

    tcs_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_a       (w_eng_a),
        .i_b       (w_eng_b),
        .i_divisor (r_lh),
        .o_acc     (w_eng_acc),
        .o_shift   (w_eng_shift)
    );

    tcs_texmem u_texmem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_ROW_OUT))
        else $error("result strobe without a completed row read");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.last) |-> (r_cur_row == r_end_row))
        else $error("last flag set before the span end");

    a_cnt_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == S_TX || r_state == S_DIV || r_state == S_MUL))
        else $error("iteration count live outside an iterating state");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

endmodule

`default_nettype wire
